// File: hw/rtl/ppc_pkg.sv
// shared types, constants and arithmetic helpers for the particle collision block
package ppc_pkg;

  localparam int CW      = 32;
  localparam int FB      = 16;
  localparam int GB      = 30 - FB;
  localparam int CF_W    = 16;
  localparam int RND_SH  = 12;
  localparam int PROD_W  = CW + CF_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int ACC_W   = SUM_W + FB + 2;
  localparam int SQ_W    = 2 * FB;
  localparam int L2_W    = 2 * FB + 2;
  localparam int RAD_W   = 64;
  localparam int ROOT_W  = 31;
  localparam int NRT     = 31;
  localparam int QW      = FB + 1;
  localparam int DR_W    = ROOT_W + 1;
  localparam int ONE     = 1 << FB;
  localparam int LIFT    = (ONE + 5000) / 10000;
  localparam int ROW_W   = 64;
  localparam int IDX_W   = 3;

  localparam logic [1:0] MODE_PLANE  = 2'd0;
  localparam logic [1:0] MODE_SPHERE = 2'd1;
  localparam logic [1:0] MODE_CUBE   = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  localparam logic [IDX_W-1:0] REG_MODE = 3'd0;
  localparam logic [IDX_W-1:0] REG_FWD0 = 3'd1;
  localparam logic [IDX_W-1:0] REG_FWD1 = 3'd2;
  localparam logic [IDX_W-1:0] REG_FWD2 = 3'd3;
  localparam logic [IDX_W-1:0] REG_INV0 = 3'd4;
  localparam logic [IDX_W-1:0] REG_INV1 = 3'd5;
  localparam logic [IDX_W-1:0] REG_INV2 = 3'd6;

  localparam logic [ROW_W-1:0] ROW0_RST = 64'd4096;
  localparam logic [ROW_W-1:0] ROW1_RST = 64'd4096 << 16;
  localparam logic [ROW_W-1:0] ROW2_RST = 64'd4096 << 32;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic [2:0][CW-1:0] pos;
    logic [2:0][CW-1:0] vel;
    logic [2:0][CW-1:0] obj;
    logic [2:0][FB-1:0] mag;
    logic [ROOT_W-1:0]  root;
    logic               hit;
    logic               zero;
  } item_t;

  function automatic logic signed [CF_W-1:0] coef(logic [ROW_W-1:0] row, int unsigned idx);
    return row[CF_W*idx +: CF_W];
  endfunction

  function automatic logic signed [CF_W-1:0] trans(logic [ROW_W-1:0] row);
    return row[ROW_W-1 -: CF_W];
  endfunction

  // round half up at the coefficient point, add translation, saturate
  function automatic coord_t row_fin(logic signed [SUM_W-1:0] s, logic signed [CF_W-1:0] t);
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] cmax;
    logic signed [ACC_W-1:0] cmin;
    cmax = ACC_W'({1'b0, {(CW-1){1'b1}}});
    cmin = -cmax - ACC_W'(1);
    acc  = (ACC_W'(s) + ACC_W'(1 << (RND_SH - 1))) >>> RND_SH;
    acc  = acc + (ACC_W'(t) <<< FB);
    if (acc > cmax) begin
      return cmax[CW-1:0];
    end else if (acc < cmin) begin
      return cmin[CW-1:0];
    end
    return acc[CW-1:0];
  endfunction

endpackage

// File: hw/rtl/particle_primitive_collision.sv
// particle collision against one transformed plane, sphere or cube primitive, or unchanged pass-through
// throughput: one item per cycle; the pipeline halts only while the output skid entry is full
// depth is set by the bit-serial square root (31 stages) and the per-lane divider (17 stages)
// reset: synchronous; clears valids, shape mode to plane, both matrices to identity
module particle_primitive_collision (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [ppc_pkg::CW-1:0]      in_pos_x,
  input  logic signed [ppc_pkg::CW-1:0]      in_pos_y,
  input  logic signed [ppc_pkg::CW-1:0]      in_pos_z,
  input  logic signed [ppc_pkg::CW-1:0]      in_vel_x,
  input  logic signed [ppc_pkg::CW-1:0]      in_vel_y,
  input  logic signed [ppc_pkg::CW-1:0]      in_vel_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [ppc_pkg::CW-1:0]      out_pos_x,
  output logic signed [ppc_pkg::CW-1:0]      out_pos_y,
  output logic signed [ppc_pkg::CW-1:0]      out_pos_z,
  output logic signed [ppc_pkg::CW-1:0]      out_vel_x,
  output logic signed [ppc_pkg::CW-1:0]      out_vel_y,
  output logic signed [ppc_pkg::CW-1:0]      out_vel_z,
  output logic                               collided,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ppc_pkg::IDX_W-1:0]          cfg_index,
  input  logic [ppc_pkg::ROW_W-1:0]          cfg_data
);

  localparam int S_SUM  = 1;
  localparam int S_OBJ  = S_SUM + 1;
  localparam int S_SQ   = 3;
  localparam int S_L2   = 4;
  localparam int S_RT0  = 5;
  localparam int S_DV0  = S_RT0 + ppc_pkg::NRT;
  localparam int S_SEL  = S_DV0 + ppc_pkg::QW;
  localparam int S_FPRD = S_SEL + 1;
  localparam int S_FSUM = S_FPRD + 1;
  localparam int S_OUT  = S_FSUM + 1;
  localparam int NST    = S_OUT + 1;

  logic [1:0]                            shape_mode;
  logic [2:0][ppc_pkg::ROW_W-1:0]        fwd_row;
  logic [2:0][ppc_pkg::ROW_W-1:0]        inv_row;

  ppc_pkg::item_t                        it      [NST];
  ppc_pkg::item_t                        it_next [NST];
  logic                                  vld     [NST];

  logic signed [ppc_pkg::PROD_W-1:0]     iprd [3][3];
  logic signed [ppc_pkg::PROD_W-1:0]     fprd [3][3];
  logic signed [ppc_pkg::SUM_W-1:0]      isum [3];
  logic signed [ppc_pkg::SUM_W-1:0]      fsum [3];
  logic [ppc_pkg::SQ_W-1:0]              sq      [3];
  logic [ppc_pkg::SQ_W-1:0]              sq_next [3];
  logic                                  box;
  logic                                  box_next;
  logic [ppc_pkg::RAD_W-1:0]             rv      [ppc_pkg::NRT+1];
  logic [ppc_pkg::RAD_W-1:0]             rv_next [ppc_pkg::NRT+1];
  logic [ppc_pkg::RAD_W-1:0]             rr      [ppc_pkg::NRT+1];
  logic [ppc_pkg::RAD_W-1:0]             rr_next [ppc_pkg::NRT+1];
  logic [ppc_pkg::DR_W-1:0]              dr      [ppc_pkg::QW][3];
  logic [ppc_pkg::DR_W-1:0]              dr_next [ppc_pkg::QW][3];
  logic [ppc_pkg::QW-1:0]                dq      [ppc_pkg::QW][3];
  logic [ppc_pkg::QW-1:0]                dq_next [ppc_pkg::QW][3];

  ppc_pkg::coord_t                       in_pos [3];
  ppc_pkg::item_t                        out_it;
  ppc_pkg::item_t                        skd;
  logic                                  skd_vld;
  logic                                  en;
  logic                                  push;
  logic                                  take;

  assign en        = !skd_vld;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;
  assign push      = en && vld[NST-1];
  assign take      = out_valid && out_ready;

  assign in_pos[0] = in_pos_x;
  assign in_pos[1] = in_pos_y;
  assign in_pos[2] = in_pos_z;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      shape_mode <= ppc_pkg::MODE_PLANE;
      fwd_row[0] <= ppc_pkg::ROW0_RST;
      fwd_row[1] <= ppc_pkg::ROW1_RST;
      fwd_row[2] <= ppc_pkg::ROW2_RST;
      inv_row[0] <= ppc_pkg::ROW0_RST;
      inv_row[1] <= ppc_pkg::ROW1_RST;
      inv_row[2] <= ppc_pkg::ROW2_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ppc_pkg::REG_MODE: shape_mode <= cfg_data[1:0];
        ppc_pkg::REG_FWD0: fwd_row[0] <= cfg_data;
        ppc_pkg::REG_FWD1: fwd_row[1] <= cfg_data;
        ppc_pkg::REG_FWD2: fwd_row[2] <= cfg_data;
        ppc_pkg::REG_INV0: inv_row[0] <= cfg_data;
        ppc_pkg::REG_INV1: inv_row[1] <= cfg_data;
        ppc_pkg::REG_INV2: inv_row[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage logic
  always_comb begin
    ppc_pkg::coord_t                o;
    ppc_pkg::coord_t                ab;
    logic [ppc_pkg::L2_W-1:0]       l2;
    logic [ppc_pkg::RAD_W-1:0]      bitv;
    logic [ppc_pkg::RAD_W-1:0]      tv;
    logic [ppc_pkg::ROOT_W-1:0]     m;
    logic [ppc_pkg::DR_W-1:0]       rin;
    logic [ppc_pkg::DR_W:0]         sh;
    logic [ppc_pkg::DR_W:0]         dsr;
    logic [ppc_pkg::QW-1:0]         qin;
    logic [ppc_pkg::QW-1:0]         n;
    logic                           boxn;

    it_next[0].pos  = {in_pos_z, in_pos_y, in_pos_x};
    it_next[0].vel  = {in_vel_z, in_vel_y, in_vel_x};
    it_next[0].obj  = '0;
    it_next[0].mag  = '0;
    it_next[0].root = '0;
    it_next[0].hit  = 1'b0;
    it_next[0].zero = 1'b0;
    for (int s = 1; s < NST; s++) begin
      it_next[s] = it[s-1];
    end

    // object space point
    for (int r = 0; r < 3; r++) begin
      it_next[S_OBJ].obj[r] = ppc_pkg::row_fin(isum[r], ppc_pkg::trans(inv_row[r]));
    end

    // magnitudes, squares, box test
    boxn = 1'b1;
    for (int l = 0; l < 3; l++) begin
      o  = ppc_pkg::coord_t'(it[S_OBJ].obj[l]);
      ab = (o < 0) ? -o : o;
      it_next[S_SQ].mag[l] = ab[ppc_pkg::FB-1:0];
      sq_next[l] = ppc_pkg::SQ_W'(ab[ppc_pkg::FB-1:0]) * ppc_pkg::SQ_W'(ab[ppc_pkg::FB-1:0]);
      boxn = boxn && (o < ppc_pkg::ONE) && (o > -ppc_pkg::ONE);
    end
    box_next = boxn;

    // hit decision and radicand
    l2 = ppc_pkg::L2_W'(sq[0]) + ppc_pkg::L2_W'(sq[1]) + ppc_pkg::L2_W'(sq[2]);
    it_next[S_L2].zero = (l2 == '0);
    case (shape_mode)
      ppc_pkg::MODE_PLANE: begin
        if (ppc_pkg::coord_t'(it[S_SQ].obj[1]) < 0) begin
          it_next[S_L2].hit    = 1'b1;
          it_next[S_L2].obj[1] = ppc_pkg::CW'(ppc_pkg::LIFT);
        end
      end
      ppc_pkg::MODE_SPHERE: begin
        it_next[S_L2].hit = box && (l2 < (ppc_pkg::L2_W'(1) << ppc_pkg::SQ_W));
      end
      ppc_pkg::MODE_CUBE: begin
        it_next[S_L2].hit = box;
      end
      default: begin
        it_next[S_L2].hit = 1'b0;
      end
    endcase
    rv_next[0] = ppc_pkg::RAD_W'(l2) << (2 * ppc_pkg::GB);
    rr_next[0] = '0;

    // square root, one result bit per stage
    for (int j = 0; j < ppc_pkg::NRT; j++) begin
      bitv = ppc_pkg::RAD_W'(1) << (2 * (ppc_pkg::NRT - 1 - j));
      tv   = rr[j] + bitv;
      if (rv[j] >= tv) begin
        rv_next[j+1] = rv[j] - tv;
        rr_next[j+1] = (rr[j] >> 1) + bitv;
      end else begin
        rv_next[j+1] = rv[j];
        rr_next[j+1] = rr[j] >> 1;
      end
    end
    it_next[S_DV0].root = rr[ppc_pkg::NRT][ppc_pkg::ROOT_W-1:0];

    // rounded division of each magnitude by the length, one quotient bit per stage
    for (int j = 0; j < ppc_pkg::QW; j++) begin
      m   = (j == 0) ? rr[ppc_pkg::NRT][ppc_pkg::ROOT_W-1:0] : it[S_DV0+j-1].root;
      dsr = {1'b0, m, 1'b0};
      for (int l = 0; l < 3; l++) begin
        if (j == 0) begin
          rin = (ppc_pkg::DR_W'(it[S_DV0-1].mag[l]) << ppc_pkg::GB)
              + ppc_pkg::DR_W'(m >> ppc_pkg::QW);
          qin = '0;
        end else begin
          rin = dr[j-1][l];
          qin = dq[j-1][l];
        end
        sh = {rin, m[ppc_pkg::QW-1-j]};
        if (sh >= dsr) begin
          dr_next[j][l] = ppc_pkg::DR_W'(sh - dsr);
          dq_next[j][l] = {qin[ppc_pkg::QW-2:0], 1'b1};
        end else begin
          dr_next[j][l] = sh[ppc_pkg::DR_W-1:0];
          dq_next[j][l] = {qin[ppc_pkg::QW-2:0], 1'b0};
        end
      end
    end

    // corrected object point and velocity
    if (it[S_SEL-1].hit && (shape_mode == ppc_pkg::MODE_SPHERE ||
                            shape_mode == ppc_pkg::MODE_CUBE)) begin
      if (it[S_SEL-1].zero) begin
        it_next[S_SEL].obj[0] = '0;
        it_next[S_SEL].obj[1] = ppc_pkg::CW'(ppc_pkg::ONE);
        it_next[S_SEL].obj[2] = '0;
      end else begin
        for (int l = 0; l < 3; l++) begin
          n = (dq[ppc_pkg::QW-1][l] > ppc_pkg::QW'(ppc_pkg::ONE)) ?
              ppc_pkg::QW'(ppc_pkg::ONE) : dq[ppc_pkg::QW-1][l];
          it_next[S_SEL].obj[l] = it[S_SEL-1].obj[l][ppc_pkg::CW-1] ?
                                  -ppc_pkg::CW'(n) : ppc_pkg::CW'(n);
        end
      end
    end
    if (it[S_SEL-1].hit && shape_mode != ppc_pkg::MODE_CUBE) begin
      it_next[S_SEL].vel = '0;
    end

    // back to world space
    for (int r = 0; r < 3; r++) begin
      it_next[S_OUT].obj[r] = (shape_mode == ppc_pkg::MODE_NONE) ? it[S_FSUM].pos[r] :
                              ppc_pkg::row_fin(fsum[r], ppc_pkg::trans(fwd_row[r]));
    end
  end

  // pipeline registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NST; s++) begin
        vld[s] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= in_valid;
      for (int s = 1; s < NST; s++) begin
        vld[s] <= vld[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NST; s++) begin
        it[s] <= it_next[s];
      end
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          iprd[r][c] <= ppc_pkg::coef(inv_row[r], c) * in_pos[c];
          fprd[r][c] <= ppc_pkg::coef(fwd_row[r], c) * ppc_pkg::coord_t'(it[S_SEL].obj[c]);
        end
        isum[r] <= ppc_pkg::SUM_W'(iprd[r][0]) + ppc_pkg::SUM_W'(iprd[r][1])
                 + ppc_pkg::SUM_W'(iprd[r][2]);
        fsum[r] <= ppc_pkg::SUM_W'(fprd[r][0]) + ppc_pkg::SUM_W'(fprd[r][1])
                 + ppc_pkg::SUM_W'(fprd[r][2]);
        sq[r]   <= sq_next[r];
      end
      box <= box_next;
      for (int j = 0; j <= ppc_pkg::NRT; j++) begin
        rv[j] <= rv_next[j];
        rr[j] <= rr_next[j];
      end
      for (int j = 0; j < ppc_pkg::QW; j++) begin
        for (int l = 0; l < 3; l++) begin
          dr[j][l] <= dr_next[j][l];
          dq[j][l] <= dq_next[j][l];
        end
      end
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skd_vld   <= 1'b0;
    end else if (skd_vld) begin
      if (take) begin
        out_it  <= skd;
        skd_vld <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || take) begin
        out_it    <= it[NST-1];
        out_valid <= 1'b1;
      end else begin
        skd     <= it[NST-1];
        skd_vld <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  assign out_pos_x = out_it.obj[0];
  assign out_pos_y = out_it.obj[1];
  assign out_pos_z = out_it.obj[2];
  assign out_vel_x = out_it.vel[0];
  assign out_vel_y = out_it.vel[1];
  assign out_vel_z = out_it.vel[2];
  assign collided  = out_it.hit;

`ifndef ASSERT_OFF
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skd_vld |-> out_valid)
    else $error("skid entry holds an item while output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skd_vld) |-> $past(out_valid && !out_ready))
    else $error("skid entry filled without a stalled output");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !skd_vld && !(en && vld[NST-1])) |=> !out_valid)
    else $error("output stays valid after its item was taken");
`endif

endmodule

// File: tb/tb_particle_primitive_collision.sv
// testbench for particle_primitive_collision: directed and random items against a local predictor
`timescale 1ns / 100ps

module tb_particle_primitive_collision;

  localparam logic [ppc_pkg::IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    ppc_pkg::coord_t px, py, pz;
    ppc_pkg::coord_t vx, vy, vz;
    logic            hit;
  } particle_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_ready;
  ppc_pkg::coord_t in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  ppc_pkg::coord_t in_vel_x = '0, in_vel_y = '0, in_vel_z = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  ppc_pkg::coord_t out_pos_x, out_pos_y, out_pos_z;
  ppc_pkg::coord_t out_vel_x, out_vel_y, out_vel_z;
  logic   collided;
  logic   cfg_valid = 1'b0;
  logic   cfg_ready;
  logic [ppc_pkg::IDX_W-1:0] cfg_index = '0;
  logic [ppc_pkg::ROW_W-1:0] cfg_data = '0;

  logic [1:0]                mdl_mode;
  logic [ppc_pkg::ROW_W-1:0] mdl_fwd [3];
  logic [ppc_pkg::ROW_W-1:0] mdl_inv [3];

  particle_t corrected_q[$];
  int        errors = 0;
  int        send_idle = 0;
  int        recv_idle = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  particle_primitive_collision uut (.*);

  // affine row: round half up at the Q4.12 point, add translation, saturate
  function automatic longint row_map(logic [ppc_pkg::ROW_W-1:0] row, longint a, longint b,
                                     longint c);
    longint s;
    s = longint'($signed(row[15:0])) * a + longint'($signed(row[31:16])) * b
      + longint'($signed(row[47:32])) * c;
    s = (s + 2048) >>> 12;
    s = s + longint'($signed(row[63:48])) * 65536;
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic particle_t predict_collision(ppc_pkg::coord_t px, py, pz, vx, vy, vz);
    particle_t res;
    longint o [3];
    longint w [3];
    longint unsigned a [3];
    longint unsigned l2, m, num, n;
    logic box;
    res = '{px, py, pz, vx, vy, vz, 1'b0};
    if (mdl_mode != ppc_pkg::MODE_NONE) begin
      for (int i = 0; i < 3; i++) o[i] = row_map(mdl_inv[i], px, py, pz);
      if (mdl_mode == ppc_pkg::MODE_PLANE) begin
        if (o[1] < 0) begin
          o[1] = longint'(ppc_pkg::LIFT);
          res.hit = 1'b1;
        end
      end else begin
        box = 1'b1;
        for (int i = 0; i < 3; i++)
          if (o[i] >= ppc_pkg::ONE || o[i] <= -ppc_pkg::ONE) box = 1'b0;
        if (mdl_mode == ppc_pkg::MODE_SPHERE) begin
          if (box) begin
            l2 = 0;
            for (int i = 0; i < 3; i++) l2 = l2 + longint'(o[i] * o[i]);
            if (l2 < (64'd1 << (2 * ppc_pkg::FB))) res.hit = 1'b1;
          end
        end else begin
          res.hit = box;
        end
        if (res.hit) begin
          l2 = 0;
          for (int i = 0; i < 3; i++) begin
            a[i] = o[i] < 0 ? -o[i] : o[i];
            l2 = l2 + a[i] * a[i];
          end
          if (l2 == 0) begin
            o[0] = 0;
            o[1] = longint'(ppc_pkg::ONE);
            o[2] = 0;
          end else begin
            m = int_sqrt(l2 << (2 * ppc_pkg::GB));
            for (int i = 0; i < 3; i++) begin
              num = a[i] << (ppc_pkg::FB + ppc_pkg::GB);
              n = (2 * num + m) / (2 * m);
              if (n > ppc_pkg::ONE) n = longint'(ppc_pkg::ONE);
              o[i] = o[i] < 0 ? -longint'(n) : longint'(n);
            end
          end
        end
      end
      if (res.hit && mdl_mode != ppc_pkg::MODE_CUBE) begin
        res.vx = '0;
        res.vy = '0;
        res.vz = '0;
      end
      for (int i = 0; i < 3; i++) w[i] = row_map(mdl_fwd[i], o[0], o[1], o[2]);
      res.px = w[0][ppc_pkg::CW-1:0];
      res.py = w[1][ppc_pkg::CW-1:0];
      res.pz = w[2][ppc_pkg::CW-1:0];
    end
    return res;
  endfunction

  task automatic send_particle(ppc_pkg::coord_t px, py, pz, vx, vy, vz);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_pos_x <= px; in_pos_y <= py; in_pos_z <= pz;
    in_vel_x <= vx; in_vel_y <= vy; in_vel_z <= vz;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    corrected_q.push_back(predict_collision(px, py, pz, vx, vy, vz));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (corrected_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_reg(logic [ppc_pkg::IDX_W-1:0] idx, logic [ppc_pkg::ROW_W-1:0] data);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ppc_pkg::REG_MODE: mdl_mode = data[1:0];
      ppc_pkg::REG_FWD0: mdl_fwd[0] = data;
      ppc_pkg::REG_FWD1: mdl_fwd[1] = data;
      ppc_pkg::REG_FWD2: mdl_fwd[2] = data;
      ppc_pkg::REG_INV0: mdl_inv[0] = data;
      ppc_pkg::REG_INV1: mdl_inv[1] = data;
      ppc_pkg::REG_INV2: mdl_inv[2] = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(string name, logic [ppc_pkg::CW-1:0] exp_v,
                             logic [ppc_pkg::CW-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    particle_t e;
    if (!rst && out_valid && out_ready) begin
      if (corrected_q.size() == 0) begin
        $error("unexpected item on output");
        errors++;
      end else begin
        e = corrected_q.pop_front();
        check_field("out_pos_x", e.px, out_pos_x);
        check_field("out_pos_y", e.py, out_pos_y);
        check_field("out_pos_z", e.pz, out_pos_z);
        check_field("out_vel_x", e.vx, out_vel_x);
        check_field("out_vel_y", e.vy, out_vel_y);
        check_field("out_vel_z", e.vz, out_vel_z);
        check_field("collided", {31'd0, e.hit}, {31'd0, collided});
      end
    end
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  function automatic ppc_pkg::coord_t rand_coord();
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return $signed($urandom_range(262143)) - 131072;
      6, 7: return $signed($urandom_range(2047)) - 1024;
      8: return $urandom;
      default: begin
        case ($urandom_range(4))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return ppc_pkg::ONE;
          3: return -ppc_pkg::ONE;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  function automatic logic [ppc_pkg::ROW_W-1:0] rand_row(int lane);
    logic [ppc_pkg::ROW_W-1:0] row;
    if ($urandom_range(4) == 0) return {$urandom, $urandom};
    for (int i = 0; i < 3; i++)
      row[16*i +: 16] = (i == lane ? 16'd4096 : 16'd0) + 16'($signed($urandom_range(600)) - 300);
    row[63:48] = 16'($signed($urandom_range(2)) - 1);
    return row;
  endfunction

  task automatic load_matrices(logic [ppc_pkg::ROW_W-1:0] f0, f1, f2, i0, i1, i2);
    write_reg(ppc_pkg::REG_FWD0, f0);
    write_reg(ppc_pkg::REG_FWD1, f1);
    write_reg(ppc_pkg::REG_FWD2, f2);
    write_reg(ppc_pkg::REG_INV0, i0);
    write_reg(ppc_pkg::REG_INV1, i1);
    write_reg(ppc_pkg::REG_INV2, i2);
  endtask

  task automatic test_plane();
    send_particle(0, -1, 0, 32'sh7fffffff, 32'sh80000000, 1);
    send_particle(100, 5, -100, 7, 8, 9);
    send_particle(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, -1, 0, 32'sh7fffffff);
    send_particle(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 0, -1, 32'sh80000000);
    send_particle(0, 0, 0, 1, 2, 3);
    wait_drained();
  endtask

  task automatic test_sphere();
    write_reg(ppc_pkg::REG_MODE, ppc_pkg::ROW_W'(ppc_pkg::MODE_SPHERE));
    send_particle(0, 0, 0, 5, 6, 7);
    send_particle(20000, -20000, 10000, 1, 1, 1);
    send_particle(ppc_pkg::ONE, 0, 0, 3, 3, 3);
    send_particle(46341, 46341, 0, 4, 4, 4);
    send_particle(-ppc_pkg::ONE + 1, 0, 0, 2, 2, 2);
    wait_drained();
  endtask

  task automatic test_cube();
    write_reg(ppc_pkg::REG_MODE, ppc_pkg::ROW_W'(ppc_pkg::MODE_CUBE));
    send_particle(0, 0, 0, 9, 9, 9);
    send_particle(ppc_pkg::ONE - 1, ppc_pkg::ONE - 1, -ppc_pkg::ONE + 1, 1, 2, 3);
    send_particle(ppc_pkg::ONE, 0, 0, 1, 2, 3);
    send_particle(-ppc_pkg::ONE, 10, 10, 1, 2, 3);
    send_particle(-300, 200, 1, -7, -8, -9);
    wait_drained();
  endtask

  task automatic test_passthrough_and_unknown_reg();
    write_reg(ppc_pkg::REG_MODE, ppc_pkg::ROW_W'(ppc_pkg::MODE_NONE));
    write_reg(REG_UNUSED, '1);
    send_particle(32'sh80000000, 123, -5, 6, 32'sh7fffffff, -ppc_pkg::ONE);
    send_particle(-ppc_pkg::ONE, 32'sh7fffffff, 0, 0, 0, 0);
    wait_drained();
  endtask

  task automatic test_matrix_extremes();
    write_reg(ppc_pkg::REG_MODE, ppc_pkg::ROW_W'(ppc_pkg::MODE_PLANE));
    load_matrices({16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff},
                  {16'h8000, 16'h8000, 16'h8000, 16'h8000},
                  '1, '0, {16'h8000, 48'h7fff_7fff_7fff}, {16'h7fff, 48'h8000_8000_8000});
    send_particle(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1, 1, 1);
    send_particle(32'sh80000000, 32'sh80000000, 32'sh80000000, 1, 1, 1);
    send_particle(ppc_pkg::ONE, -ppc_pkg::ONE, 0, 1, 1, 1);
    wait_drained();
    load_matrices(ppc_pkg::ROW0_RST, ppc_pkg::ROW1_RST, ppc_pkg::ROW2_RST,
                  ppc_pkg::ROW0_RST, ppc_pkg::ROW1_RST, ppc_pkg::ROW2_RST);
  endtask

  task automatic test_random(int n_items);
    for (int k = 0; k < n_items; k++) begin
      if (k % 40 == 0) begin
        wait_drained();
        write_reg(ppc_pkg::REG_MODE, ppc_pkg::ROW_W'(($urandom_range(9) == 0) ?
                  ppc_pkg::MODE_NONE : 2'($urandom_range(2))));
        load_matrices(rand_row(0), rand_row(1), rand_row(2), rand_row(0), rand_row(1),
                      rand_row(2));
      end
      send_particle(rand_coord(), rand_coord(), rand_coord(), $urandom, $urandom, $urandom);
    end
    wait_drained();
  endtask

  initial begin
    mdl_mode = ppc_pkg::MODE_PLANE;
    mdl_fwd = '{ppc_pkg::ROW0_RST, ppc_pkg::ROW1_RST, ppc_pkg::ROW2_RST};
    mdl_inv = '{ppc_pkg::ROW0_RST, ppc_pkg::ROW1_RST, ppc_pkg::ROW2_RST};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle = 16;
    recv_idle = 87;
    test_plane();
    test_sphere();
    test_cube();
    test_passthrough_and_unknown_reg();
    test_matrix_extremes();
    test_random(440);
    send_idle = 87;
    recv_idle = 16;
    test_random(440);
    send_idle = 0;
    recv_idle = 0;
    test_random(440);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule
